>>> src/ffpa_pkg.sv
// Shared types and constants for the first-fit page allocator.
// Used by ffpa_ctrl, ffpa_dp and first_fit_page_allocator_core; no dependencies.
`default_nettype none

package ffpa_pkg;

    localparam int DEF_PAGE_BITS   = 20;
    localparam int DEF_MAX_EXTENTS = 64;

    // Request codes.
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO_CNT = 2'd3;

    // Datapath micro-operations, one per controller step.
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_ADD,
        STEP_ALC_EV,
        STEP_SHL_EV,
        STEP_SHL_END,
        STEP_FA_EV,
        STEP_FM_INIT,
        STEP_FM_EV,
        STEP_FM_END,
        STEP_FP_EV,
        STEP_FP_END,
        STEP_SR_EV,
        STEP_INS
    } step_t;

    // Table read address select.
    typedef enum logic [1:0] {
        RD_I,
        RD_I1,
        RD_IM1
    } rd_sel_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        rd_sel_t    rd_sel;
        step_t      step;
        logic       set_status;
        logic [1:0] status;
        logic       push;
    } ffpa_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       zero_cnt;
        logic       full;
        logic       too_big;
        logic       i_end;
        logic       i1_end;
        logic       i_le_pos;
        logic       fit;
        logic       exact;
        logic       above;
        logic       any;
        logic       out_busy;
    } ffpa_stat_t;

endpackage

`default_nettype wire

>>> src/ffpa_dp.sv
// Datapath of the first-fit page allocator: extent table memory, counters and result registers.
// Depends on ffpa_pkg; driven by ffpa_ctrl.
`default_nettype none

module ffpa_dp
    import ffpa_pkg::*;
#(
    parameter int PAGE_BITS   = DEF_PAGE_BITS,
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ffpa_cmd_t            cmd,
    output ffpa_stat_t                stat,
    input  wire logic [1:0]           req_type,
    input  wire logic [PAGE_BITS-1:0] page_base,
    input  wire logic [PAGE_BITS:0]   page_count,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [PAGE_BITS-1:0]      block_base,
    output logic [PAGE_BITS:0]        free_total
);

    localparam int PB = PAGE_BITS;
    localparam int EW = 2 * PB + 1;
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0]   MAX_CNT   = CW'(MAX_EXTENTS);
    localparam logic [PB+1:0]   TOTAL_MAX = (PB+2)'(1) << PB;

    logic [EW-1:0] mem [MAX_EXTENTS];

    logic [1:0]    req_reg;
    logic [PB-1:0] base_reg;
    logic [PB:0]   n_reg;
    logic [CW-1:0] count_reg;
    logic [PB:0]   total_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] w_reg;
    logic [CW-1:0] pos_reg;
    logic [PB-1:0] start_reg;
    logic [PB+1:0] end_reg;
    logic          any_reg;
    logic [PB-1:0] got_reg;
    logic [1:0]    res_status_reg;
    logic [EW-1:0] rd_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [PB-1:0] block_base_reg;
    logic [PB:0]   free_total_reg;

    logic [PB-1:0] rb;
    logic [PB:0]   rl;
    logic [PB+1:0] rb_end;
    logic [PB+1:0] total_sum;
    logic [PB:0]   total_add;
    logic [PB+1:0] ins_diff;
    logic [PB:0]   ins_len;
    logic [CW:0]   i_plus1;
    logic [CW-1:0] raddr_full;
    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;

    assign rb        = rd_reg[EW-1:PB+1];
    assign rl        = rd_reg[PB:0];
    assign rb_end    = {2'b00, rb} + {1'b0, rl};
    assign total_sum = {1'b0, total_reg} + {1'b0, n_reg};
    assign total_add = (total_sum > TOTAL_MAX) ? TOTAL_MAX[PB:0] : total_sum[PB:0];
    assign ins_diff  = end_reg - {2'b00, start_reg};
    assign ins_len   = ins_diff[PB+1] ? {(PB+1){1'b1}} : ins_diff[PB:0];
    assign i_plus1   = {1'b0, i_reg} + (CW+1)'(1);

    always_comb
    begin
        stat.req_type = req_reg;
        stat.zero_cnt = (n_reg == '0);
        stat.full     = (count_reg == MAX_CNT);
        stat.too_big  = (n_reg > total_reg);
        stat.i_end    = (i_reg >= count_reg);
        stat.i1_end   = (i_plus1 >= {1'b0, count_reg});
        stat.i_le_pos = (i_reg <= pos_reg);
        stat.fit      = (rl >= n_reg);
        stat.exact    = (rl == n_reg);
        stat.above    = (rb > start_reg);
        stat.any      = any_reg;
        stat.out_busy = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_I:    raddr_full = i_reg;
            RD_I1:   raddr_full = i_plus1[CW-1:0];
            RD_IM1:  raddr_full = i_reg - CW'(1);
            default: raddr_full = i_reg;
        endcase
    end

    // Table write port.
    always_comb
    begin
        we    = 1'b0;
        waddr = i_reg[IW-1:0];
        wdata = rd_reg;
        case (cmd.step)
            STEP_ADD:
            begin
                we    = 1'b1;
                waddr = count_reg[IW-1:0];
                wdata = {base_reg, n_reg};
            end
            STEP_ALC_EV:
            begin
                we    = stat.fit && !stat.exact;
                wdata = {rb + n_reg[PB-1:0], rl - n_reg};
            end
            STEP_SHL_EV:
            begin
                we = 1'b1;
            end
            STEP_FM_EV:
            begin
                we    = ({2'b00, rb} != end_reg) && (rb_end != {2'b00, start_reg});
                waddr = w_reg[IW-1:0];
            end
            STEP_SR_EV:
            begin
                we = 1'b1;
            end
            STEP_INS:
            begin
                we    = 1'b1;
                waddr = pos_reg[IW-1:0];
                wdata = {start_reg, ins_len};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[raddr_full[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            req_reg        <= '0;
            base_reg       <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            pos_reg        <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            any_reg        <= 1'b0;
            got_reg        <= '0;
            res_status_reg <= ST_OK;
            status_reg     <= ST_OK;
            block_base_reg <= '0;
            free_total_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                out_valid_reg  <= 1'b1;
                status_reg     <= res_status_reg;
                block_base_reg <= got_reg;
                free_total_reg <= total_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load)
            begin
                req_reg   <= req_type;
                base_reg  <= page_base;
                n_reg     <= page_count;
                i_reg     <= '0;
                any_reg   <= 1'b0;
                start_reg <= page_base;
                end_reg   <= {2'b00, page_base} + {1'b0, page_count};
                got_reg   <= '0;
            end
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status;
            end
            case (cmd.step)
                STEP_ADD:
                begin
                    count_reg <= count_reg + CW'(1);
                    total_reg <= total_add;
                end
                STEP_ALC_EV:
                begin
                    if (stat.fit)
                    begin
                        got_reg   <= rb;
                        total_reg <= total_reg - n_reg;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                STEP_SHL_EV:
                begin
                    i_reg <= i_reg + CW'(1);
                end
                STEP_SHL_END:
                begin
                    count_reg <= count_reg - CW'(1);
                end
                STEP_FA_EV:
                begin
                    if (({2'b00, rb} == end_reg) || (rb_end == {2'b00, start_reg}))
                    begin
                        any_reg <= 1'b1;
                    end
                    i_reg <= i_reg + CW'(1);
                end
                STEP_FM_INIT:
                begin
                    i_reg <= '0;
                    w_reg <= '0;
                end
                STEP_FM_EV:
                begin
                    if ({2'b00, rb} == end_reg)
                    begin
                        end_reg <= end_reg + {1'b0, rl};
                    end
                    else if (rb_end == {2'b00, start_reg})
                    begin
                        start_reg <= rb;
                    end
                    else
                    begin
                        w_reg <= w_reg + CW'(1);
                    end
                    i_reg <= i_reg + CW'(1);
                end
                STEP_FM_END:
                begin
                    count_reg <= w_reg;
                    i_reg     <= '0;
                end
                STEP_FP_EV:
                begin
                    if (stat.above)
                    begin
                        pos_reg <= i_reg;
                        i_reg   <= count_reg;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                STEP_FP_END:
                begin
                    pos_reg <= count_reg;
                    i_reg   <= count_reg;
                end
                STEP_SR_EV:
                begin
                    i_reg <= i_reg - CW'(1);
                end
                STEP_INS:
                begin
                    count_reg <= count_reg + CW'(1);
                    total_reg <= total_add;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign block_base = block_base_reg;
    assign free_total = free_total_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("extent count above table depth");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, total_reg} <= TOTAL_MAX)
        else $error("free total above saturation limit");
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !(out_valid_reg && !out_ready))
        else $error("result pushed over a pending transaction");
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_ADD) |-> (count_reg < MAX_CNT))
        else $error("append into a full table");
`endif

endmodule

`default_nettype wire

>>> src/ffpa_ctrl.sv
// Controller state machine of the first-fit page allocator.
// Depends on ffpa_pkg; issues commands to ffpa_dp and reads its status flags.
`default_nettype none

module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire ffpa_stat_t stat,
    output ffpa_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_ALC_RD,
        S_ALC_EV,
        S_SHL_RD,
        S_SHL_EV,
        S_FA_RD,
        S_FA_EV,
        S_FM_RD,
        S_FM_EV,
        S_FP_RD,
        S_FP_EV,
        S_SR_RD,
        S_SR_EV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_I;
        cmd.step       = STEP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
                if (stat.req_type != REQ_NOP && stat.zero_cnt)
                begin
                    cmd.status = ST_ZERO_CNT;
                end
                else if (stat.req_type == REQ_ADD)
                begin
                    if (stat.full)
                    begin
                        cmd.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.step = STEP_ADD;
                    end
                end
                else if (stat.req_type == REQ_ALLOC)
                begin
                    if (stat.too_big)
                    begin
                        cmd.status = ST_NO_FIT;
                    end
                    else
                    begin
                        cmd.set_status = 1'b0;
                        state_next     = S_ALC_RD;
                    end
                end
                else if (stat.req_type == REQ_FREE)
                begin
                    cmd.set_status = 1'b0;
                    state_next     = S_FA_RD;
                end
            end
            S_ALC_RD:
            begin
                if (stat.i_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_FIT;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_ALC_EV;
                end
            end
            S_ALC_EV:
            begin
                cmd.step = STEP_ALC_EV;
                if (!stat.fit)
                begin
                    state_next = S_ALC_RD;
                end
                else if (stat.exact)
                begin
                    state_next = S_SHL_RD;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_DONE;
                end
            end
            S_SHL_RD:
            begin
                if (stat.i1_end)
                begin
                    cmd.step       = STEP_SHL_END;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_I1;
                    state_next = S_SHL_EV;
                end
            end
            S_SHL_EV:
            begin
                cmd.step   = STEP_SHL_EV;
                state_next = S_SHL_RD;
            end
            S_FA_RD:
            begin
                if (stat.i_end)
                begin
                    if (!stat.any && stat.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.step   = STEP_FM_INIT;
                        state_next = S_FM_RD;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FA_EV;
                end
            end
            S_FA_EV:
            begin
                cmd.step   = STEP_FA_EV;
                state_next = S_FA_RD;
            end
            S_FM_RD:
            begin
                if (stat.i_end)
                begin
                    cmd.step   = STEP_FM_END;
                    state_next = S_FP_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FM_EV;
                end
            end
            S_FM_EV:
            begin
                cmd.step   = STEP_FM_EV;
                state_next = S_FM_RD;
            end
            S_FP_RD:
            begin
                if (stat.i_end)
                begin
                    cmd.step   = STEP_FP_END;
                    state_next = S_SR_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FP_EV;
                end
            end
            S_FP_EV:
            begin
                cmd.step   = STEP_FP_EV;
                state_next = stat.above ? S_SR_RD : S_FP_RD;
            end
            S_SR_RD:
            begin
                if (stat.i_le_pos)
                begin
                    cmd.step       = STEP_INS;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IM1;
                    state_next = S_SR_EV;
                end
            end
            S_SR_EV:
            begin
                cmd.step   = STEP_SR_EV;
                state_next = S_SR_RD;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("request loaded outside idle");
    a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (state_reg == S_IDLE))
        else $error("push did not return to idle");
    a_disp_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DISP))
        else $error("load not followed by dispatch");
`endif

endmodule

`default_nettype wire

>>> src/first_fit_page_allocator_core.sv
// An add, a zero count or a no-op goes from dispatch straight to the done state; an allocate
// and a free scan the extent table, each entry visited in a read state and then an evaluate
// state, since the extent table has a single read port.
// Throughput: one transaction at a time; a new request is taken once the previous result
// sits in the output register, so a waiting result does not hold off the next request.
// Reset clears the extent count, the free total and the output valid; the table needs no clear.
`default_nettype none

module first_fit_page_allocator_core
    import ffpa_pkg::*;
#(
    parameter int PAGE_BITS   = DEF_PAGE_BITS,
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           req_type,
    input  wire logic [PAGE_BITS-1:0] page_base,
    input  wire logic [PAGE_BITS:0]   page_count,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [PAGE_BITS-1:0]      block_base,
    output logic [PAGE_BITS:0]        free_total
);

    // The controller sequences each request through scan passes over the table;
    // the datapath holds the table, the request registers and the result register.
    ffpa_cmd_t  cmd;
    ffpa_stat_t stat;

    ffpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffpa_dp #(
        .PAGE_BITS   (PAGE_BITS),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .page_base  (page_base),
        .page_count (page_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .block_base (block_base),
        .free_total (free_total)
    );

endmodule

`default_nettype wire

>>> tb/first_fit_page_allocator_core_tb.sv
// Self-checking testbench for first_fit_page_allocator_core.
// Needs ffpa_pkg and the core; predicts every response from a local model of the extent table.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_page_allocator_core_tb
    import ffpa_pkg::*;
();

    localparam int PB = DEF_PAGE_BITS;
    localparam int MX = DEF_MAX_EXTENTS;
    localparam logic [PB:0] TOTAL_CAP = (PB+1)'(1) << PB;
    localparam logic [PB+1:0] LEN_CAP = {1'b0, {(PB+1){1'b1}}};

    typedef struct packed {
        logic [1:0]    kind;
        logic [PB-1:0] base;
        logic [PB:0]   count;
    } request_t;

    typedef struct packed {
        logic [1:0]    st;
        logic [PB-1:0] got;
        logic [PB:0]   total;
    } response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] req_type = '0;
    logic [PB-1:0] page_base = '0;
    logic [PB:0] page_count = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [PB-1:0] block_base;
    logic [PB:0] free_total;

    first_fit_page_allocator_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .page_base(page_base), .page_count(page_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .block_base(block_base), .free_total(free_total)
    );

    always #6 clk = ~clk;

    // Predictor state: a copy of the extent table. Extents are kept wider than the
    // port widths so that end-of-range compares happen at full precision.
    logic [PB+1:0] ext_base [MX+1];
    logic [PB+1:0] ext_len [MX+1];
    int ext_n;
    logic [PB:0] pages_free;

    request_t pending_reqs[$];
    response_t expected_resp[$];
    request_t next_req;
    int errors = 0;
    int sent = 0;
    int seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    // Acceptance seen at the rising edge, used by the driver on the next falling edge.
    logic in_ready_s = 1'b0;

    function automatic void credit(logic [PB+1:0] n);
        logic [PB+2:0] t;
        t = {1'b0, {1'b0, pages_free}} + {1'b0, n};
        pages_free = (t > {2'b00, TOTAL_CAP}) ? TOTAL_CAP : t[PB:0];
    endfunction

    // Applies one request to the local table and returns the response it should give.
    function automatic response_t allocator_predict(request_t r);
        response_t p;
        logic [PB+1:0] n, st, en, b, l;
        int w, pos;
        bit any, done;
        p = '0;
        n = {1'b0, r.count};
        if (r.kind != REQ_NOP && r.count == '0)
        begin
            p.st = ST_ZERO_CNT;
        end
        else if (r.kind == REQ_ADD)
        begin
            if (ext_n >= MX)
            begin
                p.st = ST_FULL;
            end
            else
            begin
                ext_base[ext_n] = {2'b00, r.base};
                ext_len[ext_n] = n;
                ext_n++;
                credit(n);
            end
        end
        else if (r.kind == REQ_ALLOC)
        begin
            p.st = ST_NO_FIT;
            if (n <= {1'b0, pages_free})
            begin
                done = 0;
                for (int i = 0; i < ext_n && !done; i++)
                begin
                    if (ext_len[i] >= n)
                    begin
                        done = 1;
                        p.st = ST_OK;
                        p.got = ext_base[i][PB-1:0];
                        if (ext_len[i] > n)
                        begin
                            ext_base[i] = {2'b00, ext_base[i][PB-1:0] + n[PB-1:0]};
                            ext_len[i] = ext_len[i] - n;
                        end
                        else
                        begin
                            for (int k = i; k + 1 < ext_n; k++)
                            begin
                                ext_base[k] = ext_base[k+1];
                                ext_len[k] = ext_len[k+1];
                            end
                            ext_n--;
                        end
                        pages_free = pages_free - n[PB:0];
                    end
                end
            end
        end
        else if (r.kind == REQ_FREE)
        begin
            st = {2'b00, r.base};
            en = {2'b00, r.base} + n;
            any = 0;
            for (int i = 0; i < ext_n; i++)
            begin
                if (ext_base[i] == en || ext_base[i] + ext_len[i] == st)
                begin
                    any = 1;
                end
            end
            if (!any && ext_n >= MX)
            begin
                p.st = ST_FULL;
            end
            else
            begin
                w = 0;
                for (int i = 0; i < ext_n; i++)
                begin
                    b = ext_base[i];
                    l = ext_len[i];
                    if (b == en)
                    begin
                        en = en + l;
                    end
                    else if (b + l == st)
                    begin
                        st = b;
                    end
                    else
                    begin
                        ext_base[w] = b;
                        ext_len[w] = l;
                        w++;
                    end
                end
                ext_n = w;
                pos = ext_n;
                for (int i = ext_n - 1; i >= 0; i--)
                begin
                    if (ext_base[i] > st)
                    begin
                        pos = i;
                    end
                end
                for (int i = ext_n; i > pos; i--)
                begin
                    ext_base[i] = ext_base[i-1];
                    ext_len[i] = ext_len[i-1];
                end
                ext_base[pos] = {2'b00, st[PB-1:0]};
                ext_len[pos] = ((en - st) > LEN_CAP) ? LEN_CAP : (en - st);
                ext_n++;
                credit(n);
            end
        end
        p.total = pages_free;
        return p;
    endfunction

    // Driver: offers queued requests; valid holds until the transaction is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready_s)
            begin
                sent++;
            end
            if ((!in_valid || in_ready_s) && pending_reqs.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                expected_resp.push_back(allocator_predict(next_req));
                req_type <= next_req.kind;
                page_base <= next_req.base;
                page_count <= next_req.count;
                in_valid <= 1'b1;
            end
            else if (in_valid && in_ready_s)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        in_ready_s <= in_valid && in_ready;
    end

    // Monitor: compares each accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            response_t e;
            seen++;
            if (expected_resp.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d base=%0d total=%0d",
                         $time, status, block_base, free_total);
                errors++;
            end
            else
            begin
                e = expected_resp.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (block_base !== e.got)
                begin
                    $display("%0t: block_base expected %0d actual %0d", $time, e.got,
                             block_base);
                    errors++;
                end
                if (free_total !== e.total)
                begin
                    $display("%0t: free_total expected %0d actual %0d", $time, e.total,
                             free_total);
                    errors++;
                end
            end
        end
    end

    function automatic request_t make_req(logic [1:0] k, logic [PB-1:0] b, logic [PB:0] c);
        request_t r;
        r.kind = k;
        r.base = b;
        r.count = c;
        return r;
    endfunction

    // Random mix mostly of small counts so fits, merges and a filling table all occur.
    function automatic request_t random_req();
        int sel;
        logic [PB:0] c;
        logic [PB-1:0] b;
        sel = $urandom_range(99);
        c = ($urandom_range(19) == 0) ? (PB+1)'($urandom_range((1 << (PB + 1)) - 1, 0))
                                      : (PB+1)'($urandom_range(40, 0));
        b = ($urandom_range(9) == 0) ? PB'($urandom) : PB'($urandom_range(4095) * 16);
        if (sel < 25)
        begin
            return make_req(REQ_ADD, b, c);
        end
        if (sel < 60)
        begin
            return make_req(REQ_ALLOC, PB'($urandom), c);
        end
        if (sel < 97)
        begin
            return make_req(REQ_FREE, b, c);
        end
        return make_req(REQ_NOP, PB'($urandom), c);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_resp.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (8 * MX + 20) @(posedge clk);
    endtask

    initial
    begin
        ext_n = 0;
        pages_free = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero counts, no-op type, extremes, merging both sides, wrap.
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, 21'd5));
        pending_reqs.push_back(make_req(REQ_ADD, 20'd100, '0));
        pending_reqs.push_back(make_req(REQ_NOP, '1, '1));
        pending_reqs.push_back(make_req(REQ_ADD, 20'd100, 21'd50));
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, 21'd60));
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, 21'd20));
        pending_reqs.push_back(make_req(REQ_FREE, 20'd100, 21'd20));
        pending_reqs.push_back(make_req(REQ_FREE, 20'd10, 21'd90));
        pending_reqs.push_back(make_req(REQ_FREE, 20'd150, 21'd5));
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, 21'd145));
        pending_reqs.push_back(make_req(REQ_ADD, '1, 21'd4));
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, 21'd2));
        pending_reqs.push_back(make_req(REQ_ADD, '0, 21'h100000));
        pending_reqs.push_back(make_req(REQ_ADD, 20'd7, '1));
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, '1));
        pending_reqs.push_back(make_req(REQ_FREE, '1, '1));
        pending_reqs.push_back(make_req(REQ_ALLOC, '0, 21'h100000));
        pending_reqs.push_back(make_req(REQ_FREE, '0, '0));
        for (int i = 0; i < 70; i++)
        begin
            pending_reqs.push_back(make_req(REQ_ADD, 20'(i * 1000), 21'd1));
        end
        pending_reqs.push_back(make_req(REQ_FREE, 20'd500, 21'd3));
        pending_reqs.push_back(make_req(REQ_FREE, 20'd1001, 21'd3));
        wait_drained();

        // Back-pressure: a long receiver hold-off while requests keep coming.
        for (int i = 0; i < 20; i++)
        begin
            pending_reqs.push_back(random_req());
        end
        hold_cycles = 3000;
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 54 : 35) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 54 : 35) : 0;
            for (int i = 0; i < 500; i++)
            begin
                pending_reqs.push_back(random_req());
            end
            wait_drained();
        end

        $display("tb: %0d requests sent and %0d responses checked over four idle phases",
                 sent, seen);
        $display("tb: covered adds, first-fit allocates, merging frees and table-full cases");
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
